[design/adt_pkg.sv]
// shared types, codes and defaults for the advertising data target filter
// no dependencies; used by adt_cfg, adt_walker and adv_data_target_filter
`timescale 1ns / 1ps
`default_nettype none

package adt_pkg;

  localparam int unsigned NameCompareMaxDefault = 31;
  localparam int unsigned AdvMaxLenDefault      = 31;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 64;
  localparam int unsigned PrefixBytes  = 32;

  // ad structure type codes that the walk tracks
  localparam logic [7:0] AdTypeUuid16Incomplete = 8'h02;
  localparam logic [7:0] AdTypeUuid16Complete   = 8'h03;
  localparam logic [7:0] AdTypeNameShort        = 8'h08;
  localparam logic [7:0] AdTypeNameComplete     = 8'h09;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgTargetUuid  = 3'd0,
    CfgPrefixLen   = 3'd1,
    CfgPrefix0     = 3'd2,
    CfgPrefix1     = 3'd3,
    CfgPrefix2     = 3'd4,
    CfgPrefix3     = 3'd5
  } adt_cfg_idx_e;

  typedef enum logic [1:0] {
    PhLen   = 2'd0,
    PhType  = 2'd1,
    PhValue = 2'd2,
    PhStop  = 2'd3
  } adt_phase_e;

  // settings as the walker sees them
  typedef struct packed {
    logic [15:0]              target_uuid;
    logic                     prefix_on;
    logic [4:0]               eff_len;
    logic                     eff_last_zero;
    logic [PrefixBytes*8-1:0] prefix;
  } adt_cfg_t;

  // one result item, service_match in the lowest bit
  typedef struct packed {
    logic connect;
    logic name_present;
    logic prefix_match;
    logic service_match;
  } adt_result_t;

endpackage

`default_nettype wire

[design/adt_cfg.sv]
// configuration registers plus registered prefix summary (effective length)
// depends on adt_pkg
`timescale 1ns / 1ps
`default_nettype none

module adt_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [adt_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire logic [adt_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output adt_pkg::adt_cfg_t                       cfg_o
);

  logic [15:0] target_uuid_q;
  logic [4:0]  prefix_len_q;
  logic [63:0] prefix0_q, prefix1_q, prefix2_q, prefix3_q;
  logic [4:0]  eff_len_d, eff_len_q;
  logic        eff_last_zero_d, eff_last_zero_q;
  logic [adt_pkg::PrefixBytes*8-1:0] prefix_all;

  assign prefix_all = {prefix3_q, prefix2_q, prefix1_q, prefix0_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_uuid_q <= '0;
      prefix_len_q  <= '0;
      prefix0_q     <= '0;
      prefix1_q     <= '0;
      prefix2_q     <= '0;
      prefix3_q     <= '0;
    end else if (cfg_we_i) begin
      case (adt_pkg::adt_cfg_idx_e'(cfg_index_i))
        adt_pkg::CfgTargetUuid: target_uuid_q <= cfg_data_i[15:0];
        adt_pkg::CfgPrefixLen:  prefix_len_q  <= cfg_data_i[4:0];
        adt_pkg::CfgPrefix0:    prefix0_q     <= cfg_data_i;
        adt_pkg::CfgPrefix1:    prefix1_q     <= cfg_data_i;
        adt_pkg::CfgPrefix2:    prefix2_q     <= cfg_data_i;
        adt_pkg::CfgPrefix3:    prefix3_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // compare stops one past the first zero byte inside the prefix
  always_comb begin
    eff_len_d = prefix_len_q;
    for (int i = adt_pkg::PrefixBytes - 2; i >= 0; i--) begin
      if ((5'(i) < prefix_len_q) && (prefix_all[i*8 +: 8] == 8'h00)) begin
        eff_len_d = 5'(i + 1);
      end
    end
    eff_last_zero_d = (eff_len_d != 5'd0) &&
                      (prefix_all[(eff_len_d - 5'd1)*8 +: 8] == 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_len_q       <= '0;
      eff_last_zero_q <= 1'b0;
    end else begin
      eff_len_q       <= eff_len_d;
      eff_last_zero_q <= eff_last_zero_d;
    end
  end

  assign cfg_o.target_uuid   = target_uuid_q;
  assign cfg_o.prefix_on     = (prefix_len_q != 5'd0);
  assign cfg_o.eff_len       = eff_len_q;
  assign cfg_o.eff_last_zero = eff_last_zero_q;
  assign cfg_o.prefix        = prefix_all;

endmodule

`default_nettype wire

[design/adt_walker.sv]
// length-type-value walk over one packet, per-type commit flags and result
// depends on adt_pkg
`timescale 1ns / 1ps
`default_nettype none

module adt_walker #(
  parameter int unsigned NAME_COMPARE_MAX = adt_pkg::NameCompareMaxDefault,
  parameter int unsigned ADV_MAX_LEN      = adt_pkg::AdvMaxLenDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [7:0]           byte_i,
  input  wire logic                 last_i,
  input  wire adt_pkg::adt_cfg_t    cfg_i,
  output adt_pkg::adt_result_t      result_o
);

  adt_pkg::adt_phase_e phase_d, phase_q;
  logic [7:0] pos_d, pos_q;
  logic [7:0] rem_d, rem_q;
  logic [7:0] type_d, type_q;
  logic [7:0] off_d, off_q;
  logic [7:0] hold_d, hold_q;
  logic       tent_d, tent_q;
  logic [7:0] flags_d, flags_q;
  logic [7:0] flags_end;
  logic       present, nm_raw, sm, nm;

  function automatic logic is_name(input logic [7:0] t);
    is_name = (t == adt_pkg::AdTypeNameComplete) || (t == adt_pkg::AdTypeNameShort);
  endfunction

  function automatic logic is_uuid(input logic [7:0] t);
    is_uuid = (t == adt_pkg::AdTypeUuid16Complete) || (t == adt_pkg::AdTypeUuid16Incomplete);
  endfunction

  // first complete field of each tracked type sets its found and match bits
  function automatic logic [7:0] commit(input logic [7:0] flags, input logic [7:0] t,
                                        input logic [7:0] off, input logic tent,
                                        input adt_pkg::adt_cfg_t c);
    logic [2:0] sh;
    logic       tracked;
    logic       m;
    logic [7:0] ln;
    logic [7:0] eff;
    sh      = 3'd0;
    tracked = 1'b1;
    case (t)
      adt_pkg::AdTypeNameComplete:     sh = 3'd0;
      adt_pkg::AdTypeNameShort:        sh = 3'd2;
      adt_pkg::AdTypeUuid16Complete:   sh = 3'd4;
      adt_pkg::AdTypeUuid16Incomplete: sh = 3'd6;
      default:                         tracked = 1'b0;
    endcase
    ln  = (off > 8'(NAME_COMPARE_MAX)) ? 8'(NAME_COMPARE_MAX) : off;
    eff = {3'b000, c.eff_len};
    if (is_name(t)) begin
      m = tent && ((ln >= eff) || (c.eff_last_zero && ((ln + 8'd1) == eff)));
    end else begin
      m = tent;
    end
    commit = flags;
    if (tracked && !flags[sh]) begin
      commit[sh]        = 1'b1;
      commit[sh + 3'd1] = m;
    end
  endfunction

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    type_d  = type_q;
    off_d   = off_q;
    hold_d  = hold_q;
    tent_d  = tent_q;
    flags_d = flags_q;
    pos_d   = (pos_q != 8'hFF) ? pos_q + 8'd1 : pos_q;

    if (phase_q != adt_pkg::PhStop) begin
      if (pos_q >= 8'(ADV_MAX_LEN)) begin
        phase_d = adt_pkg::PhStop;
      end else begin
        case (phase_q)
          adt_pkg::PhLen: begin
            if (byte_i == 8'h00) begin
              phase_d = adt_pkg::PhStop;
            end else begin
              rem_d   = byte_i;
              phase_d = adt_pkg::PhType;
            end
          end
          adt_pkg::PhType: begin
            type_d = byte_i;
            rem_d  = rem_q - 8'd1;
            off_d  = 8'd0;
            hold_d = 8'd0;
            tent_d = is_name(byte_i);
            if (rem_d == 8'd0) begin
              flags_d = commit(flags_q, type_d, off_d, tent_d, cfg_i);
              phase_d = adt_pkg::PhLen;
            end else begin
              phase_d = adt_pkg::PhValue;
            end
          end
          default: begin
            if (is_name(type_q)) begin
              if ((off_q < {3'b000, cfg_i.eff_len}) && (off_q < 8'(NAME_COMPARE_MAX)) &&
                  (byte_i != cfg_i.prefix[off_q[4:0]*8 +: 8])) begin
                tent_d = 1'b0;
              end
            end else if (is_uuid(type_q)) begin
              if (!off_q[0]) begin
                hold_d = byte_i;
              end else if ({byte_i, hold_q} == cfg_i.target_uuid) begin
                tent_d = 1'b1;
              end
            end
            off_d = (off_q != 8'hFF) ? off_q + 8'd1 : off_q;
            rem_d = rem_q - 8'd1;
            if (rem_d == 8'd0) begin
              flags_d = commit(flags_q, type_q, off_d, tent_d, cfg_i);
              phase_d = adt_pkg::PhLen;
            end
          end
        endcase
      end
    end

    flags_end = flags_d;

    // the last item of a packet closes it out
    if (last_i) begin
      phase_d = adt_pkg::PhLen;
      pos_d   = 8'd0;
      rem_d   = 8'd0;
      type_d  = 8'd0;
      off_d   = 8'd0;
      hold_d  = 8'd0;
      tent_d  = 1'b0;
      flags_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= adt_pkg::PhLen;
      pos_q   <= '0;
      rem_q   <= '0;
      type_q  <= '0;
      off_q   <= '0;
      hold_q  <= '0;
      tent_q  <= 1'b0;
      flags_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      type_q  <= type_d;
      off_q   <= off_d;
      hold_q  <= hold_d;
      tent_q  <= tent_d;
      flags_q <= flags_d;
    end
  end

  // complete name wins over short name, complete list over incomplete list
  always_comb begin
    present = flags_end[0] | flags_end[2];
    nm_raw  = flags_end[0] ? flags_end[1] : flags_end[3];
    sm      = flags_end[4] ? flags_end[5] : flags_end[7];
    nm      = cfg_i.prefix_on ? (present & nm_raw) : 1'b1;
    result_o.service_match = sm;
    result_o.prefix_match  = nm;
    result_o.name_present  = present;
    result_o.connect       = cfg_i.prefix_on ? nm : sm;
  end

endmodule

`default_nettype wire

[design/adv_data_target_filter.sv]
// advertising data target filter: input item register, walker, result register
// depends on adt_pkg, adt_cfg and adt_walker
//
//   port group      dir   contents
//   s_axis_*        in    one advertising byte per item, tlast on the packet's last byte
//   m_axis_*        out   one result item per packet
//   cfg_*           in    register writes, index 0 to 5
//
// one byte per cycle while no packet's last byte waits on a full result register; a result
// passes from the input item register through the walker step into the result register.
// reset zeroes the walk state, config registers and valid flags, prefix matching off.
// bytes keep flowing while a result waits; only a packet's last byte stalls when the
// result register is still full.
`timescale 1ns / 1ps
`default_nettype none

module adv_data_target_filter #(
  parameter int unsigned NAME_COMPARE_MAX = adt_pkg::NameCompareMaxDefault,
  parameter int unsigned ADV_MAX_LEN      = adt_pkg::AdvMaxLenDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output wire logic                             s_axis_tready,
  input  wire logic [7:0]                       s_axis_tdata,  // [7:0] adv_byte
  input  wire logic                             s_axis_tlast,  // last_byte
  output wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [0] service_match, [1] prefix_match, [2] name_present, [3] connect, [7:4] zero
  output wire logic [7:0]                       m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [adt_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [adt_pkg::CfgDataWidth-1:0] cfg_data_i
);

  adt_pkg::adt_cfg_t    cfg;
  adt_pkg::adt_result_t result;
  adt_pkg::adt_result_t out_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       step;
  logic       load_out;
  logic       in_take;

  // a byte with no result never waits on the output side
  assign step     = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign load_out = step && in_last_q;
  assign s_axis_tready = !in_valid_q || step;
  assign in_take  = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  adt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  adt_walker #(
    .NAME_COMPARE_MAX (NAME_COMPARE_MAX),
    .ADV_MAX_LEN      (ADV_MAX_LEN)
  ) u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q};

  // input side stalls only behind a waiting last byte and a full, unread result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_last_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // a result appears only from a packet's last byte
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step && in_last_q))
    else $error("result without a last byte");

  // a finished packet always shows its result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_last_q) |=> m_axis_tvalid)
    else $error("last byte processed but no result");

endmodule

`default_nettype wire

[test/adt_filter_checker.sv]
// checker for the advertising data target filter: tracks register writes, predicts
// one verdict per packet from the byte stream and compares it with each result item
// depends on adt_pkg
`timescale 1ns / 1ps

module adt_filter_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] adv_byte
  input  logic                             s_axis_tlast,  // last_byte
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] service_match, [1] prefix_match, [2] name_present, [3] connect, [7:4] zero
  input  logic [7:0]                       m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [adt_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [adt_pkg::CfgDataWidth-1:0] cfg_data_i,
  output int unsigned                      pending_o,
  output int unsigned                      errors_o
);
  import adt_pkg::*;

  localparam int unsigned NameMax   = NameCompareMaxDefault;
  localparam int unsigned AdvMax    = AdvMaxLenDefault;
  localparam int unsigned PrefixMax = 31;

  // each slot owns a bit pair in seen_flags: found, then match
  localparam int SlotNameComplete = 0;
  localparam int SlotNameShort    = 1;
  localparam int SlotUuidComplete = 2;
  localparam int SlotUuidShort    = 3;
  localparam int SlotNone         = -1;

  logic [15:0] target_uuid;
  logic [4:0]  prefix_len;
  logic [63:0] prefix_word [4];

  logic [7:0]  byte_pos;
  adt_phase_e  phase;
  logic [7:0]  field_left;
  logic [7:0]  field_kind;
  logic [7:0]  value_idx;
  logic [7:0]  uuid_lo;
  logic        field_hit;
  logic [7:0]  seen_flags;

  adt_result_t verdict_q [$];
  int unsigned mismatches;

  function automatic logic [7:0] prefix_at(input int unsigned i);
    logic [63:0] w;
    w = prefix_word[(i >> 3) & 3] >> ((i & 7) * 8);
    return w[7:0];
  endfunction

  // positions taken into the compare: up to and including the first zero byte
  function automatic int unsigned compare_len();
    int unsigned i;
    for (i = 0; i < prefix_len; i++) begin
      if (prefix_at(i) == 8'h00) return i + 1;
    end
    return prefix_len;
  endfunction

  function automatic int slot_of(input logic [7:0] kind);
    case (kind)
      AdTypeNameComplete:     return SlotNameComplete;
      AdTypeNameShort:        return SlotNameShort;
      AdTypeUuid16Complete:   return SlotUuidComplete;
      AdTypeUuid16Incomplete: return SlotUuidShort;
      default:                return SlotNone;
    endcase
  endfunction

  function automatic logic is_name(input logic [7:0] kind);
    return kind == AdTypeNameComplete || kind == AdTypeNameShort;
  endfunction

  function automatic string field_name(input int i);
    case (i)
      0:       return "service_match";
      1:       return "prefix_match";
      2:       return "name_present";
      default: return "connect";
    endcase
  endfunction

  task automatic clear_packet();
    byte_pos   = '0;
    phase      = PhLen;
    field_left = '0;
    field_kind = '0;
    value_idx  = '0;
    uuid_lo    = '0;
    field_hit  = 1'b0;
    seen_flags = '0;
  endtask

  // only the first complete field of each tracked type is kept
  task automatic close_field();
    int          slot;
    int unsigned eff;
    int unsigned ln;
    logic        hit;
    slot = slot_of(field_kind);
    if (slot == SlotNone) return;
    if (seen_flags[2*slot]) return;
    if (is_name(field_kind)) begin
      eff = compare_len();
      ln  = (value_idx > NameMax) ? NameMax : value_idx;
      // a name one byte short still matches when the prefix ends in a zero byte
      hit = field_hit && (ln >= eff ||
            (eff >= 1 && ln + 1 == eff && prefix_at(eff - 1) == 8'h00));
    end else begin
      hit = field_hit;
    end
    seen_flags[2*slot]   = 1'b1;
    seen_flags[2*slot+1] = hit;
  endtask

  task automatic take_value(input logic [7:0] b);
    if (is_name(field_kind)) begin
      if (value_idx < compare_len() && value_idx < NameMax && value_idx < PrefixMax &&
          b != prefix_at(value_idx))
        field_hit = 1'b0;
    end else if (field_kind == AdTypeUuid16Complete || field_kind == AdTypeUuid16Incomplete) begin
      if (!value_idx[0]) uuid_lo = b;
      else if ({b, uuid_lo} == target_uuid) field_hit = 1'b1;
    end
    if (value_idx != 8'hFF) value_idx++;
  endtask

  task automatic walk_adv_byte(input logic [7:0] b, input logic last);
    adt_result_t v;
    logic        any_name;
    logic        name_hit;
    logic        uuid_hit;
    logic        prefix_on;
    if (phase != PhStop) begin
      if (byte_pos >= AdvMax) begin
        phase = PhStop;
      end else begin
        case (phase)
          PhLen: begin
            if (b == 8'h00) begin
              phase = PhStop;
            end else begin
              field_left = b;
              phase      = PhType;
            end
          end
          PhType: begin
            field_kind = b;
            field_left--;
            value_idx  = '0;
            uuid_lo    = '0;
            field_hit  = is_name(b);
            if (field_left == 0) begin
              close_field();
              phase = PhLen;
            end else begin
              phase = PhValue;
            end
          end
          default: begin
            take_value(b);
            field_left--;
            if (field_left == 0) begin
              close_field();
              phase = PhLen;
            end
          end
        endcase
      end
    end
    if (byte_pos != 8'hFF) byte_pos++;
    if (last) begin
      any_name  = seen_flags[2*SlotNameComplete] | seen_flags[2*SlotNameShort];
      name_hit  = seen_flags[2*SlotNameComplete] ? seen_flags[2*SlotNameComplete+1]
                                                 : seen_flags[2*SlotNameShort+1];
      uuid_hit  = seen_flags[2*SlotUuidComplete] ? seen_flags[2*SlotUuidComplete+1]
                                                 : seen_flags[2*SlotUuidShort+1];
      prefix_on = prefix_len != 0;
      v.service_match = uuid_hit;
      v.prefix_match  = prefix_on ? (any_name && name_hit) : 1'b1;
      v.name_present  = any_name;
      v.connect       = prefix_on ? v.prefix_match : uuid_hit;
      verdict_q.push_back(v);
      clear_packet();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    adt_result_t got;
    adt_result_t want;
    int          i;
    if (!rst_ni) begin
      target_uuid = '0;
      prefix_len  = '0;
      for (i = 0; i < 4; i++) prefix_word[i] = '0;
      clear_packet();
      verdict_q.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgTargetUuid: target_uuid    = cfg_data_i[15:0];
          CfgPrefixLen:  prefix_len     = cfg_data_i[4:0];
          CfgPrefix0:    prefix_word[0] = cfg_data_i;
          CfgPrefix1:    prefix_word[1] = cfg_data_i;
          CfgPrefix2:    prefix_word[2] = cfg_data_i;
          CfgPrefix3:    prefix_word[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) walk_adv_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[3:0];
        if (verdict_q.size() == 0) begin
          $display("%0t: result %b arrived with no packet outstanding", $time, got);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          for (i = 0; i < 4; i++) begin
            if (want[i] !== got[i]) begin
              $display("%0t: %s expected %0b actual %0b", $time, field_name(i), want[i], got[i]);
              mismatches++;
            end
          end
        end
      end
      pending_o <= verdict_q.size();
      errors_o  <= mismatches;
    end
  end

endmodule

[test/tb_adv_data_target_filter.sv]
// top of the advertising data target filter testbench: clock, reset, packet stimulus,
// register settings, result-side stalls and the verdict
// depends on adt_pkg, adv_data_target_filter and adt_filter_checker
`timescale 1ns / 1ps

module tb_adv_data_target_filter;
  import adt_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBytes = 800;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 4;
  // indexes past the register list, written to show they are ignored
  localparam logic [CfgIdxWidth-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CfgSpareHi = 3'd7;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata  = '0;
  logic                    s_axis_tlast  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [7:0]              m_axis_tdata;
  logic                    cfg_we_i      = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index_i   = '0;
  logic [CfgDataWidth-1:0] cfg_data_i    = '0;

  int unsigned pending_cnt;
  int unsigned fail_cnt;
  int unsigned cycles = 0;

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 45;
  logic        hold_req  = 1'b0;
  logic        hold_ack  = 1'b0;
  int unsigned hold_left = 0;

  // settings the stimulus aims at
  logic [15:0] cur_uuid;
  logic [4:0]  cur_plen;
  logic [7:0]  cur_name [32];
  logic [7:0]  pkt_q [$];

  adv_data_target_filter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  adt_filter_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending_cnt),
    .errors_o     (fail_cnt)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when asked for
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_packet();
    int unsigned i;
    for (i = 0; i < pkt_q.size(); i++) send_item(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  // wait until every packet has its result, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxWidth-1:0] idx, input logic [CfgDataWidth-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] prefix_word(input int unsigned r);
    logic [63:0] w;
    int unsigned j;
    for (j = 0; j < 8; j++) w[j*8 +: 8] = cur_name[r*8 + j];
    return w;
  endfunction

  // upper data bits are random: the block must drop them
  task automatic write_settings();
    cfg_write(CfgTargetUuid, {16'($urandom), $urandom, cur_uuid});
    cfg_write(CfgPrefixLen, {$urandom, 27'($urandom), cur_plen});
    cfg_write(CfgPrefix0, prefix_word(0));
    cfg_write(CfgPrefix1, prefix_word(1));
    cfg_write(CfgPrefix2, prefix_word(2));
    cfg_write(CfgPrefix3, prefix_word(3));
    cfg_write(CfgSpareLo, {$urandom, $urandom});
    cfg_write(CfgSpareHi, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_settings(input int unsigned ph);
    int unsigned i;
    cur_uuid = 16'($urandom);
    cur_plen = 5'($urandom);
    for (i = 0; i < 32; i++) cur_name[i] = 8'($urandom_range(1, 255));
    case (ph)
      0: begin
        cur_uuid = '0;
        cur_plen = '0;
        for (i = 0; i < 32; i++) cur_name[i] = 8'h00;
      end
      1: begin
        cur_uuid = '1;
        cur_plen = 5'd31;
        for (i = 0; i < 32; i++) cur_name[i] = 8'hFF;
      end
      2: cur_plen = 5'($urandom_range(1, 8));
      3: begin
        // zero byte inside the prefix ends the compare early
        cur_plen = 5'($urandom_range(2, 31));
        cur_name[$urandom_range(0, cur_plen - 1)] = 8'h00;
      end
      4: cur_plen = '0;
      default: for (i = 0; i < 32; i++) cur_name[i] = 8'($urandom);
    endcase
  endtask

  // names mostly follow the prefix, around its length, with the odd corrupted byte
  task automatic add_name_field(input logic [7:0] kind);
    int unsigned n;
    int unsigned i;
    logic [7:0]  b;
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(0, 30);
    end else begin
      n = cur_plen + $urandom_range(0, 2);
      n = (n == 0) ? 0 : n - 1;
    end
    pkt_q.push_back(8'(n + 1));
    pkt_q.push_back(kind);
    for (i = 0; i < n; i++) begin
      b = (i < 32) ? cur_name[i] : 8'($urandom);
      if ($urandom_range(0, 3 * n) == 0) b = 8'($urandom);
      pkt_q.push_back(b);
    end
  endtask

  task automatic add_uuid_field(input logic [7:0] kind);
    int unsigned pairs;
    logic        odd;
    logic [15:0] u;
    pairs = $urandom_range(0, 4);
    odd   = ($urandom_range(3) == 0);
    pkt_q.push_back(8'(2 * pairs + odd + 1));
    pkt_q.push_back(kind);
    repeat (pairs) begin
      u = ($urandom_range(2) == 0) ? cur_uuid : 16'($urandom);
      pkt_q.push_back(u[7:0]);
      pkt_q.push_back(u[15:8]);
    end
    if (odd) pkt_q.push_back(8'($urandom));
  endtask

  task automatic add_other_field();
    int unsigned n;
    n = $urandom_range(0, 6);
    pkt_q.push_back(8'(n + 1));
    pkt_q.push_back(8'($urandom));
    repeat (n) pkt_q.push_back(8'($urandom));
  endtask

  task automatic make_packet();
    int unsigned n;
    pkt_q.delete();
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 40)) pkt_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(5))
          0:       add_name_field(AdTypeNameComplete);
          1:       add_name_field(AdTypeNameShort);
          2:       add_uuid_field(AdTypeUuid16Complete);
          3:       add_uuid_field(AdTypeUuid16Incomplete);
          default: add_other_field();
        endcase
      end
      case ($urandom_range(9))
        0: begin
          // zero length stops the walk; the rest is ignored
          pkt_q.push_back(8'h00);
          repeat ($urandom_range(0, 3)) pkt_q.push_back(8'($urandom));
        end
        1: begin
          // field that runs past the end of the packet
          pkt_q.push_back(8'($urandom_range(8, 40)));
          pkt_q.push_back($urandom_range(1) ? AdTypeNameComplete : AdTypeUuid16Complete);
          repeat ($urandom_range(0, 3)) pkt_q.push_back(8'($urandom));
        end
        2: begin
          n = $urandom_range(32, 40);
          while (pkt_q.size() < n) pkt_q.push_back(8'($urandom));
        end
        default: ;
      endcase
    end
  endtask

  initial begin
    int unsigned ph;
    int unsigned sent;
    int unsigned i;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_uuid = 16'h1234;
    cur_plen = 5'd2;
    for (i = 0; i < 32; i++) cur_name[i] = 8'($urandom);
    cur_name[0] = 8'h41;
    cur_name[1] = 8'h42;
    write_settings();
    // zero length as the only byte
    pkt_q = '{8'h00};
    send_packet();
    // length byte as the final byte
    pkt_q = '{8'h07};
    send_packet();
    // empty name, then a list with the target and an odd trailing byte
    pkt_q = '{8'h01, 8'h09, 8'h04, 8'h03, 8'h34, 8'h12, 8'hFF};
    send_packet();
    // short name, zero length stop, a byte after the stop
    pkt_q = '{8'h03, 8'h08, 8'h41, 8'h42, 8'h00, 8'h55};
    send_packet();
    // list cut off by the end of the packet
    pkt_q = '{8'h05, 8'h02, 8'h34, 8'h12};
    send_packet();
    // untracked type, then the complete name
    pkt_q = '{8'h02, 8'hFF, 8'h80, 8'h03, 8'h09, 8'h41, 8'h42};
    send_packet();
    settle();

    for (ph = 0; ph < NumPhases; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 45;
        recv_idle_pct = 19;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick_settings(ph);
      write_settings();
      if (ph == 0) hold_req <= ~hold_req;
      sent = 0;
      while (sent < RandomBytes / NumPhases) begin
        make_packet();
        send_packet();
        sent += pkt_q.size();
      end
      settle();
    end

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
design/adt_pkg.sv
design/adt_cfg.sv
design/adt_walker.sv
design/adv_data_target_filter.sv
test/adt_filter_checker.sv
test/tb_adv_data_target_filter.sv
